>>> design/qou_pkg.sv
// ---------------------------------------------------------------------------
// qou_pkg: shared types and constants of the quaternion orientation unit
// Operation codes, Q2.14 constants and the Hamilton product term table.
// ---------------------------------------------------------------------------
package qou_pkg;

   typedef logic signed [15:0] comp_type;
   typedef logic [1:0]         op_type;

   localparam op_type OP_LOAD = 2'd0;
   localparam op_type OP_MUL  = 2'd1;
   localparam op_type OP_INT  = 2'd2;
   localparam op_type OP_NORM = 2'd3;

   localparam comp_type Q_ONE = 16'sd16384;
   localparam int       COMP_W = 16;

   // one term a[x] * b[y] of a Hamilton product component, with its sign
   typedef struct packed {
      logic [1:0] a_idx;
      logic [1:0] b_idx;
      logic       neg;
   } term_type;

   // serial multiplier control
   typedef struct packed {
      logic     start;
      comp_type a;
      comp_type b;
   } mul_req_type;

   function automatic term_type term_lookup(input logic [1:0] comp, input logic [1:0] term);
      term_type t;
      t = '{a_idx: 2'd0, b_idx: 2'd0, neg: 1'b0};
      unique case ({comp, term})
         4'h0: t = '{a_idx: 2'd0, b_idx: 2'd0, neg: 1'b0};
         4'h1: t = '{a_idx: 2'd1, b_idx: 2'd1, neg: 1'b1};
         4'h2: t = '{a_idx: 2'd2, b_idx: 2'd2, neg: 1'b1};
         4'h3: t = '{a_idx: 2'd3, b_idx: 2'd3, neg: 1'b1};
         4'h4: t = '{a_idx: 2'd0, b_idx: 2'd1, neg: 1'b0};
         4'h5: t = '{a_idx: 2'd1, b_idx: 2'd0, neg: 1'b0};
         4'h6: t = '{a_idx: 2'd2, b_idx: 2'd3, neg: 1'b0};
         4'h7: t = '{a_idx: 2'd3, b_idx: 2'd2, neg: 1'b1};
         4'h8: t = '{a_idx: 2'd0, b_idx: 2'd2, neg: 1'b0};
         4'h9: t = '{a_idx: 2'd2, b_idx: 2'd0, neg: 1'b0};
         4'ha: t = '{a_idx: 2'd3, b_idx: 2'd1, neg: 1'b0};
         4'hb: t = '{a_idx: 2'd1, b_idx: 2'd3, neg: 1'b1};
         4'hc: t = '{a_idx: 2'd0, b_idx: 2'd3, neg: 1'b0};
         4'hd: t = '{a_idx: 2'd3, b_idx: 2'd0, neg: 1'b0};
         4'he: t = '{a_idx: 2'd1, b_idx: 2'd2, neg: 1'b0};
         4'hf: t = '{a_idx: 2'd2, b_idx: 2'd1, neg: 1'b1};
         default: t = '{a_idx: 2'd0, b_idx: 2'd0, neg: 1'b0};
      endcase
      return t;
   endfunction

endpackage

>>> design/qou_mul.sv
// ---------------------------------------------------------------------------
// qou_mul: bit-serial signed 16x16 multiplier
// Shift-add over the multiplier bits, one bit per cycle, sign bit
// weighted negative; done pulses in the cycle after the sixteenth step.
// ---------------------------------------------------------------------------
module qou_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  qou_pkg::mul_req_type mul_req,
   output logic                 done,
   output logic signed [31:0]   prod
);
   import qou_pkg::*;

   logic signed [17:0] hi_ff, hi_in;
   logic [15:0]        lo_ff, lo_in;
   comp_type           mc_ff, mc_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [17:0] addend;
   logic signed [17:0] sum;

   // one multiplier bit per cycle
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend  = '0;
      sum     = hi_ff;
      if (mul_req.start) begin
         hi_in   = '0;
         lo_in   = mul_req.b;
         mc_in   = mul_req.a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (lo_ff[0]) begin
            addend = (cnt_ff == 4'd15) ? -18'(mc_ff) : 18'(mc_ff);
         end
         sum    = hi_ff + addend;
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[15:1]};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mc_ff  <= mc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff[15:0], lo_ff};

endmodule

>>> design/quaternion_orientation_unit.sv
// Load passes the input straight on; multiply and integrate run one serial product
// per term; normalize sums the squares, then per component a square and root search.
// One item at a time: the input stalls until the item is committed.
// An item is taken while the previous result still waits on the output.
// Reset (synchronous, active high) sets the orientation to identity, clears valid.
// ---------------------------------------------------------------------------
// quaternion_orientation_unit: stored orientation quaternion in Q2.14
// Load, Hamilton multiply, vector integrate and normalize, with saturation
// and zero-norm flags; arithmetic through one bit-serial multiplier.
// ---------------------------------------------------------------------------
module quaternion_orientation_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qou_pkg::op_type    req_op,
   input  qou_pkg::comp_type  req_in_r,
   input  qou_pkg::comp_type  req_in_i,
   input  qou_pkg::comp_type  req_in_j,
   input  qou_pkg::comp_type  req_in_k,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qou_pkg::comp_type  rsp_out_r,
   output qou_pkg::comp_type  rsp_out_i,
   output qou_pkg::comp_type  rsp_out_j,
   output qou_pkg::comp_type  rsp_out_k,
   output logic               rsp_saturated,
   output logic               rsp_zero_norm
);
   import qou_pkg::*;

   localparam int NW = 70;
   localparam int AW = 38;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_PROD  = 3'd2;
   localparam logic [2:0] S_DSQ   = 3'd3;
   localparam logic [2:0] S_CSQ   = 3'd4;
   localparam logic [2:0] S_ITER  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   op_type              op_ff, op_in;
   comp_type            s_ff [4];
   comp_type            s_in [4];
   comp_type            q_ff [4];
   comp_type            q_in [4];
   comp_type            res_ff [4];
   comp_type            res_in [4];
   comp_type            out_ff [4];
   comp_type            out_in [4];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [1:0]          comp_ff, comp_in;
   logic [1:0]          term_ff, term_in;
   logic                sat_ff, sat_in, zn_ff, zn_in;
   logic                osat_ff, osat_in, ozn_ff, ozn_in;
   logic                vld_ff, vld_in;
   logic [33:0]         d_ff, d_in;
   logic signed [NW-1:0] r_ff, r_in, da_ff, da_in;
   logic [14:0]         n_ff, n_in;
   logic [3:0]          bit_ff, bit_in;
   logic                neg_ff, neg_in;

   mul_req_type         mul_req;
   logic                mul_done;
   logic signed [31:0]  mul_prod;

   term_type            tcur, tnxt;
   logic signed [AW-1:0] pext, acc_sum, rnd_val, rnd_sh;
   logic signed [NW-1:0] dext, delta, trial;
   logic [4:0]          sh_a, sh_b;
   logic                fire;

   qou_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .prod    (mul_prod)
   );

   assign fire = req_valid && !req_stall;

   // sequence items through the serial multiplier and the root search
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      s_in     = s_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      acc_in   = acc_ff;
      comp_in  = comp_ff;
      term_in  = term_ff;
      sat_in   = sat_ff;
      zn_in    = zn_ff;
      osat_in  = osat_ff;
      ozn_in   = ozn_ff;
      vld_in   = vld_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      da_in    = da_ff;
      n_in     = n_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      mul_req  = '{start: 1'b0, a: '0, b: '0};
      tcur     = term_lookup(comp_ff, term_ff);
      tnxt     = term_lookup(comp_ff, term_ff + 2'd1);
      pext     = AW'(mul_prod);
      acc_sum  = tcur.neg ? acc_ff - pext : acc_ff + pext;
      rnd_val  = '0;
      rnd_sh   = '0;
      dext     = $signed({{(NW-34){1'b0}}, d_ff});
      sh_a     = 5'(bit_ff) + 5'd2;
      sh_b     = {bit_ff, 1'b0} + 5'd2;
      delta    = (da_ff <<< sh_a) + (dext <<< sh_b);
      trial    = r_ff - delta;

      // drop the result on the output when the consumer is free
      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               op_in  = req_op;
               s_in[0] = (req_op == OP_INT) ? '0 : req_in_r;
               s_in[1] = req_in_i;
               s_in[2] = req_in_j;
               s_in[3] = req_in_k;
               sat_in = 1'b0;
               zn_in  = 1'b0;
               comp_in = '0;
               term_in = '0;
               acc_in  = '0;
               d_in    = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            tcur = term_lookup(2'd0, 2'd0);
            if (op_ff == OP_LOAD) begin
               res_in   = s_ff;
               state_in = S_DONE;
            end else if (op_ff == OP_NORM) begin
               mul_req  = '{start: 1'b1, a: q_ff[0], b: q_ff[0]};
               state_in = S_DSQ;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a = (op_ff == OP_MUL) ? q_ff[tcur.a_idx] : s_ff[tcur.a_idx];
               mul_req.b = (op_ff == OP_MUL) ? s_ff[tcur.b_idx] : q_ff[tcur.b_idx];
               state_in  = S_PROD;
            end
         end
         S_PROD: begin
            if (mul_done) begin
               if (term_ff != 2'd3) begin
                  acc_in  = acc_sum;
                  term_in = term_ff + 2'd1;
                  mul_req.start = 1'b1;
                  mul_req.a = (op_ff == OP_MUL) ? q_ff[tnxt.a_idx] : s_ff[tnxt.a_idx];
                  mul_req.b = (op_ff == OP_MUL) ? s_ff[tnxt.b_idx] : q_ff[tnxt.b_idx];
               end else begin
                  // round half up, then clip to the 16-bit range
                  if (op_ff == OP_INT) begin
                     rnd_val = acc_sum + (AW'(q_ff[comp_ff]) <<< 15) + AW'(32'sd16384);
                     rnd_sh  = rnd_val >>> 15;
                  end else begin
                     rnd_val = acc_sum + AW'(32'sd8192);
                     rnd_sh  = rnd_val >>> 14;
                  end
                  if (rnd_sh > AW'(32'sd32767)) begin
                     res_in[comp_ff] = 16'sh7fff;
                     sat_in = 1'b1;
                  end else if (rnd_sh < -AW'(32'sd32768)) begin
                     res_in[comp_ff] = 16'sh8000;
                     sat_in = 1'b1;
                  end else begin
                     res_in[comp_ff] = rnd_sh[15:0];
                  end
                  acc_in  = '0;
                  term_in = '0;
                  if (comp_ff != 2'd3) begin
                     comp_in = comp_ff + 2'd1;
                     tnxt = term_lookup(comp_ff + 2'd1, 2'd0);
                     mul_req.start = 1'b1;
                     mul_req.a = (op_ff == OP_MUL) ? q_ff[tnxt.a_idx] : s_ff[tnxt.a_idx];
                     mul_req.b = (op_ff == OP_MUL) ? s_ff[tnxt.b_idx] : q_ff[tnxt.b_idx];
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DSQ: begin
            // accumulate the squared norm
            if (mul_done) begin
               d_in = d_ff + 34'(mul_prod[30:0]);
               if (comp_ff != 2'd3) begin
                  comp_in = comp_ff + 2'd1;
                  mul_req = '{start: 1'b1, a: q_ff[comp_ff + 2'd1], b: q_ff[comp_ff + 2'd1]};
               end else if (d_in == '0) begin
                  res_in[0] = Q_ONE;
                  res_in[1] = '0;
                  res_in[2] = '0;
                  res_in[3] = '0;
                  zn_in     = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  comp_in  = '0;
                  mul_req  = '{start: 1'b1, a: q_ff[0], b: q_ff[0]};
                  state_in = S_CSQ;
               end
            end
         end
         S_CSQ: begin
            if (mul_done) begin
               r_in     = (NW'(mul_prod) <<< 30) - dext;
               da_in    = -dext;
               n_in     = '0;
               bit_in   = 4'd14;
               neg_in   = q_ff[comp_ff][15];
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            // try one result bit per cycle
            if ((bit_ff == 4'd14 || !n_ff[14]) && trial >= 0) begin
               r_in  = trial;
               da_in = da_ff + (dext <<< (5'(bit_ff) + 5'd1));
               n_in  = n_ff | (15'd1 << bit_ff);
            end
            if (bit_ff == 4'd0) begin
               state_in = S_FIN;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         S_FIN: begin
            // final round-up step and sign restore
            trial = r_ff - ((da_ff <<< 2) + (dext <<< 2));
            n_in  = n_ff;
            if (!n_ff[14] && trial >= 0) begin
               n_in = n_ff + 15'd1;
            end
            res_in[comp_ff] = neg_ff ? -$signed({1'b0, n_in}) : $signed({1'b0, n_in});
            if (comp_ff != 2'd3) begin
               comp_in  = comp_ff + 2'd1;
               mul_req  = '{start: 1'b1, a: q_ff[comp_ff + 2'd1], b: q_ff[comp_ff + 2'd1]};
               state_in = S_CSQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // commit once the output register is free
            if (!vld_ff || !rsp_stall) begin
               q_in     = res_ff;
               out_in   = res_ff;
               osat_in  = sat_ff;
               ozn_in   = zn_ff;
               vld_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      s_ff    <= s_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      acc_ff  <= acc_in;
      comp_ff <= comp_in;
      term_ff <= term_in;
      sat_ff  <= sat_in;
      zn_ff   <= zn_in;
      osat_ff <= osat_in;
      ozn_ff  <= ozn_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
      da_ff   <= da_in;
      n_ff    <= n_in;
      bit_ff  <= bit_in;
      neg_ff  <= neg_in;
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         q_ff[0]  <= Q_ONE;
         q_ff[1]  <= '0;
         q_ff[2]  <= '0;
         q_ff[3]  <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         q_ff     <= q_in;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = vld_ff;
   assign rsp_out_r     = out_ff[0];
   assign rsp_out_i     = out_ff[1];
   assign rsp_out_j     = out_ff[2];
   assign rsp_out_k     = out_ff[3];
   assign rsp_saturated = osat_ff;
   assign rsp_zero_norm = ozn_ff;

`ifndef SYNTHESIS
   // both flags never come from one item
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_saturated && rsp_zero_norm))
      else $error("saturated and zero_norm both set");

   // an accepted item holds off the next one
   a_busy_after_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> req_stall)
      else $error("input not stalled after accept");

   // multiplier results arrive only while a product is awaited
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_PROD || state_ff == S_DSQ || state_ff == S_CSQ))
      else $error("stray multiplier result");

   // normalize results stay within unit magnitude
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (n_ff <= 15'd16384))
      else $error("normalize magnitude out of range");
`endif

endmodule
